FILE: design/crg_pkg.sv
package crg_pkg;

   // field and register widths
   localparam int COORD_BITS     = 12;
   localparam int CFG_BITS       = 31;
   localparam int WORD_BITS      = 32;
   localparam int ENTRY_COUNT    = 12;
   localparam int INDEX_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;

   // datapath widths
   localparam int MAG_BITS  = 31;
   localparam int SUM_BITS  = 64;
   localparam int ROOT_BITS = 32;
   localparam int QUO_BITS  = 31;
   localparam int FRAC_DIR  = 30;

   // item commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_SIZE  = 2'd2;

   // reset values
   localparam logic [CFG_BITS-1:0]         HALF_RESET       = 31'd65536;
   localparam logic [CFG_BITS-1:0]         PIXEL_SIZE_RESET = 31'd256;
   localparam logic signed [WORD_BITS-1:0] Q16_ONE          = 32'sd65536;

   typedef struct packed {
      logic                        cmd;
      logic [COORD_BITS-1:0]       pixel_x;
      logic [COORD_BITS-1:0]       pixel_y;
      logic [INDEX_BITS-1:0]       entry_index;
      logic signed [WORD_BITS-1:0] entry_value;
   } crg_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] origin_x;
      logic signed [WORD_BITS-1:0] origin_y;
      logic signed [WORD_BITS-1:0] origin_z;
      logic signed [WORD_BITS-1:0] dir_x;
      logic signed [WORD_BITS-1:0] dir_y;
      logic signed [WORD_BITS-1:0] dir_z;
   } crg_rsp_type;

   // normalized ray travelling beside the root and divide pipes
   typedef struct packed {
      logic                           zero;
      logic [2:0]                     neg;
      logic [2:0][MAG_BITS-1:0]       mag;
      logic [2:0][WORD_BITS-1:0]      origin;
   } crg_ray_type;

endpackage

FILE: design/crg_req_if.sv
interface crg_req_if;
   import crg_pkg::*;

   logic        valid;
   logic        ready;
   crg_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/crg_rsp_if.sv
interface crg_rsp_if;
   import crg_pkg::*;

   logic        valid;
   logic        ready;
   crg_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/crg_front.sv
module crg_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_accept,
   input  crg_pkg::crg_req_type                  in_data,
   input  logic                                  csr_we,
   input  logic [crg_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [crg_pkg::CFG_BITS-1:0]          csr_wdata,
   output logic                                  out_valid,
   output crg_pkg::crg_ray_type                  out_ray,
   output logic [crg_pkg::SUM_BITS-1:0]          out_sum
);
   import crg_pkg::*;

   localparam int OFF_BITS = COORD_BITS + 1 + CFG_BITS;
   localparam int W2_BITS  = OFF_BITS + 2;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int RND_BITS = PROD_BITS - 16;
   localparam int D_BITS   = RND_BITS + 2;
   localparam int A_BITS   = D_BITS - 1;
   localparam int POS_BITS = $clog2(A_BITS);
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam logic [POS_BITS-1:0] NORM_TOP = POS_BITS'(MAG_BITS - 1);

   // stored state
   logic [ENTRY_COUNT-1:0][WORD_BITS-1:0] mat_ff;
   logic [CFG_BITS-1:0]                   half_w_ff, half_h_ff, pix_ff;

   // stage registers
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic [OFF_BITS-1:0]                   offx1_ff, offy1_ff;
   logic [ENTRY_COUNT-1:0][WORD_BITS-1:0] mat1_ff, mat2_ff;
   logic signed [WORD_BITS-1:0]           wx2_ff, wy2_ff;
   logic [2:0][1:0][PROD_BITS-1:0]        prod3_ff;
   logic [2:0][WORD_BITS-1:0]             m2_3_ff, org3_ff, org4_ff, org5_ff, org6_ff;
   logic [2:0][D_BITS-1:0]                d4_ff;
   logic [2:0][A_BITS-1:0]                a5_ff, a6_ff;
   logic [2:0]                            neg5_ff, neg6_ff;
   logic [POS_BITS-1:0]                   pos6_ff;
   logic                                  zero6_ff;
   crg_ray_type                           ray7_ff, ray8_ff, ray9_ff;
   logic [2:0][SQ_BITS-1:0]               sq8_ff;
   logic [SUM_BITS-1:0]                   sum9_ff;

   // next values
   logic [OFF_BITS-1:0]            offx1_in, offy1_in;
   logic signed [WORD_BITS-1:0]    wx2_in, wy2_in;
   logic [2:0][1:0][PROD_BITS-1:0] prod3_in;
   logic [2:0][D_BITS-1:0]         d4_in;
   logic [2:0][A_BITS-1:0]         a5_in;
   logic [2:0]                     neg5_in;
   logic [POS_BITS-1:0]            pos6_in;
   logic                           zero6_in;
   crg_ray_type                    ray7_in;
   logic [2:0][SQ_BITS-1:0]        sq8_in;
   logic [SUM_BITS-1:0]            sum9_in;

   function automatic logic signed [WORD_BITS-1:0] sat32(input logic signed [W2_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] res;
      if ((&v[W2_BITS-1:WORD_BITS-1]) || !(|v[W2_BITS-1:WORD_BITS-1])) begin
         res = v[WORD_BITS-1:0];
      end else if (v[W2_BITS-1]) begin
         res = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_w_ff <= HALF_RESET;
         half_h_ff <= HALF_RESET;
         pix_ff    <= PIXEL_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:  half_w_ff <= csr_wdata;
            CSR_HALF_HEIGHT: half_h_ff <= csr_wdata;
            CSR_PIXEL_SIZE:  pix_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // inverse transform, loaded one entry per load transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            mat_ff[i] <= (i == 0 || i == 5 || i == 10) ? Q16_ONE : '0;
         end
      end else if (in_accept && in_data.cmd == CMD_LOAD &&
                   in_data.entry_index < INDEX_BITS'(ENTRY_COUNT)) begin
         mat_ff[in_data.entry_index] <= in_data.entry_value;
      end
   end

   // stage 1: pixel centre offset times pixel size
   always_comb begin
      offx1_in = OFF_BITS'({in_data.pixel_x, 1'b1}) * OFF_BITS'(pix_ff);
      offy1_in = OFF_BITS'({in_data.pixel_y, 1'b1}) * OFF_BITS'(pix_ff);
   end

   // stage 2: subtract from the half extents, halve with rounding, saturate
   always_comb begin
      logic signed [W2_BITS-1:0] w2x, w2y, hx, hy;
      w2x = $signed(W2_BITS'({half_w_ff, 1'b0})) - $signed(W2_BITS'(offx1_ff));
      w2y = $signed(W2_BITS'({half_h_ff, 1'b0})) - $signed(W2_BITS'(offy1_ff));
      hx  = (w2x + W2_BITS'(1)) >>> 1;
      hy  = (w2y + W2_BITS'(1)) >>> 1;
      wx2_in = sat32(hx);
      wy2_in = sat32(hy);
   end

   // stage 3: six products of matrix and plane point
   always_comb begin
      logic signed [WORD_BITS-1:0] c0, c1;
      logic signed [PROD_BITS-1:0] p0, p1;
      prod3_in = '0;
      for (int r = 0; r < 3; r++) begin
         c0 = $signed(mat2_ff[r*4]);
         c1 = $signed(mat2_ff[r*4+1]);
         p0 = c0 * wx2_ff;
         p1 = c1 * wy2_ff;
         prod3_in[r][0] = p0;
         prod3_in[r][1] = p1;
      end
   end

   // stage 4: round products back to Q16.16 and subtract the z column
   always_comb begin
      logic signed [PROD_BITS-1:0] r0, r1;
      d4_in = '0;
      for (int r = 0; r < 3; r++) begin
         r0 = ($signed(prod3_ff[r][0]) + PROD_BITS'(32768)) >>> 16;
         r1 = ($signed(prod3_ff[r][1]) + PROD_BITS'(32768)) >>> 16;
         d4_in[r] = D_BITS'($signed(r0[RND_BITS-1:0])) + D_BITS'($signed(r1[RND_BITS-1:0]))
                    - D_BITS'($signed(m2_3_ff[r]));
      end
   end

   // stage 5: magnitudes and signs
   always_comb begin
      logic signed [D_BITS-1:0] dv;
      a5_in   = '0;
      neg5_in = '0;
      for (int r = 0; r < 3; r++) begin
         dv = $signed(d4_ff[r]);
         neg5_in[r] = dv[D_BITS-1];
         a5_in[r]   = A_BITS'(neg5_in[r] ? -dv : dv);
      end
   end

   // stage 6: leading one of the largest magnitude
   always_comb begin
      logic [A_BITS-1:0] any_a;
      any_a   = a5_ff[0] | a5_ff[1] | a5_ff[2];
      zero6_in = ~|any_a;
      pos6_in  = '0;
      for (int i = 0; i < A_BITS; i++) begin
         if (any_a[i]) pos6_in = POS_BITS'(i);
      end
   end

   // stage 7: normalize so the largest magnitude sits at bit 30
   always_comb begin
      ray7_in.zero   = zero6_ff;
      ray7_in.neg    = neg6_ff;
      ray7_in.origin = org6_ff;
      ray7_in.mag    = '0;
      for (int r = 0; r < 3; r++) begin
         if (zero6_ff) begin
            ray7_in.mag[r] = '0;
         end else if (pos6_ff < NORM_TOP) begin
            ray7_in.mag[r] = MAG_BITS'(a6_ff[r] << (NORM_TOP - pos6_ff));
         end else begin
            ray7_in.mag[r] = MAG_BITS'(a6_ff[r] >> (pos6_ff - NORM_TOP));
         end
      end
   end

   // stage 8: squares
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sq8_in[r] = SQ_BITS'(ray7_ff.mag[r]) * SQ_BITS'(ray7_ff.mag[r]);
      end
   end

   // stage 9: sum of squares
   assign sum9_in = SUM_BITS'(sq8_ff[0]) + SUM_BITS'(sq8_ff[1]) + SUM_BITS'(sq8_ff[2]);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         v7_ff <= 1'b0; v8_ff <= 1'b0; v9_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_accept && in_data.cmd == CMD_PIXEL;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= v5_ff; v7_ff <= v6_ff;
         v8_ff <= v7_ff; v9_ff <= v8_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         offx1_ff <= offx1_in;
         offy1_ff <= offy1_in;
         mat1_ff  <= mat_ff;
         wx2_ff   <= wx2_in;
         wy2_ff   <= wy2_in;
         mat2_ff  <= mat1_ff;
         prod3_ff <= prod3_in;
         for (int r = 0; r < 3; r++) begin
            m2_3_ff[r] <= mat2_ff[r*4+2];
            org3_ff[r] <= mat2_ff[r*4+3];
         end
         d4_ff    <= d4_in;
         org4_ff  <= org3_ff;
         a5_ff    <= a5_in;
         neg5_ff  <= neg5_in;
         org5_ff  <= org4_ff;
         a6_ff    <= a5_ff;
         pos6_ff  <= pos6_in;
         zero6_ff <= zero6_in;
         neg6_ff  <= neg5_ff;
         org6_ff  <= org5_ff;
         ray7_ff  <= ray7_in;
         ray8_ff  <= ray7_ff;
         sq8_ff   <= sq8_in;
         ray9_ff  <= ray8_ff;
         sum9_ff  <= sum9_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_ray   = ray9_ff;
   assign out_sum   = sum9_ff;

endmodule

FILE: design/crg_isqrt.sv
module crg_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  crg_pkg::crg_ray_type            in_ray,
   input  logic [crg_pkg::SUM_BITS-1:0]    in_sum,
   output logic                            out_valid,
   output crg_pkg::crg_ray_type            out_ray,
   output logic [crg_pkg::ROOT_BITS-1:0]   out_root
);
   import crg_pkg::*;

   localparam int STEPS = ROOT_BITS;

   logic                val_ff  [STEPS];
   logic [SUM_BITS-1:0] rem_ff  [STEPS];
   logic [SUM_BITS-1:0] root_ff [STEPS];
   crg_ray_type         side_ff [STEPS];

   // one result bit per stage, restoring square root
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic [SUM_BITS-1:0] STEP_BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2*i);

      logic                vld_prev;
      logic [SUM_BITS-1:0] rem_prev, root_prev, cand, rem_in, root_in;
      crg_ray_type         side_prev;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = in_sum;
         assign root_prev = '0;
         assign side_prev = in_ray;
      end else begin : g_next
         assign vld_prev  = val_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // trial subtract
      always_comb begin
         cand = root_prev + STEP_BIT;
         if (rem_prev >= cand) begin
            rem_in  = rem_prev - cand;
            root_in = (root_prev >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i] <= 1'b0;
         end else if (advance) begin
            val_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = val_ff[STEPS-1];
   assign out_ray   = side_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1][ROOT_BITS-1:0];

endmodule

FILE: design/crg_div.sv
module crg_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  crg_pkg::crg_ray_type                  in_ray,
   input  logic [crg_pkg::ROOT_BITS-1:0]         in_len,
   output logic                                  out_valid,
   output crg_pkg::crg_ray_type                  out_ray,
   output logic [2:0][crg_pkg::QUO_BITS-1:0]     out_quo
);
   import crg_pkg::*;

   localparam int STEPS    = QUO_BITS;
   localparam int NUM_BITS = MAG_BITS + FRAC_DIR + 1;

   logic                          val_ff  [STEPS];
   logic [2:0][NUM_BITS-1:0]      rem_ff  [STEPS];
   logic [2:0][QUO_BITS-1:0]      quo_ff  [STEPS];
   logic [ROOT_BITS-1:0]          len_ff  [STEPS];
   crg_ray_type                   side_ff [STEPS];

   // three lanes of restoring division, one quotient bit per stage
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = QUO_BITS - 1 - j;

      logic                     vld_prev;
      logic [2:0][NUM_BITS-1:0] rem_prev, rem_in;
      logic [2:0][QUO_BITS-1:0] quo_prev, quo_in;
      logic [ROOT_BITS-1:0]     len_prev;
      logic [NUM_BITS-1:0]      dsh;
      crg_ray_type              side_prev;

      if (j == 0) begin : g_first
         // numerator: magnitude scaled to Q2.30 plus half the length for rounding
         always_comb begin
            for (int r = 0; r < 3; r++) begin
               rem_prev[r] = (NUM_BITS'(in_ray.mag[r]) << FRAC_DIR)
                             + NUM_BITS'(in_len >> 1);
            end
         end
         assign vld_prev  = in_valid;
         assign quo_prev  = '0;
         assign len_prev  = in_len;
         assign side_prev = in_ray;
      end else begin : g_next
         assign vld_prev  = val_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign len_prev  = len_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // compare and subtract the shifted divisor
      always_comb begin
         dsh    = NUM_BITS'(len_prev) << K;
         rem_in = rem_prev;
         quo_in = quo_prev;
         for (int r = 0; r < 3; r++) begin
            if (rem_prev[r] >= dsh) begin
               rem_in[r]    = rem_prev[r] - dsh;
               quo_in[r][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[j] <= 1'b0;
         end else if (advance) begin
            val_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in;
            quo_ff[j]  <= quo_in;
            len_ff[j]  <= len_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = val_ff[STEPS-1];
   assign out_ray   = side_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];

endmodule

FILE: design/camera_ray_generator_top.sv
// Pinhole camera ray generator, Q16.16 fixed point.
// req_ch carries load and pixel items. A load transfer (cmd 0) writes one
// entry of the 3x4 inverse camera matrix and gives no result; an entry index
// above 11 is ignored. A pixel transfer (cmd 1) gives one result on rsp_ch:
// the ray origin (translation column) and the unit direction in Q2.30.
// The csr_ port writes the view half extents and the pixel pitch;
// write it only while no pixel is in flight.
// A pixel's result passes 9 front stages, 32 square-root stages, 31 divide
// stages and the output register on its way to rsp_ch.
// Throughput: one item per cycle unless rsp_ch stalls, loads and pixels
// mixed freely. Each pixel takes the matrix as it stands at its own transfer.
// When rsp_ch stalls, the output register holds the result and the pipe
// keeps moving until its last stage holds an item too; then every stage
// freezes and req_ch.ready drops. Nothing is lost or repeated.
// Reset (synchronous) empties the pipe, sets the matrix to identity,
// half extents to 1.0 and pixel size to 256 (2^-8).
module camera_ray_generator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   crg_req_if.sink                              req_ch,
   crg_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [crg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [crg_pkg::CFG_BITS-1:0]         csr_wdata
);
   import crg_pkg::*;

   logic                     advance, out_load, in_accept;
   logic                     front_valid, root_valid, div_valid;
   crg_ray_type              front_ray, root_ray, div_ray;
   logic [SUM_BITS-1:0]      front_sum;
   logic [ROOT_BITS-1:0]     root_len;
   logic [2:0][QUO_BITS-1:0] div_quo;
   logic                     out_valid_ff;
   crg_rsp_type              out_data_ff, out_data_in;

   // stall control: the pipe moves unless its last item cannot leave
   assign out_load  = !out_valid_ff || rsp_ch.ready;
   assign advance   = !div_valid || out_load;
   assign in_accept = req_ch.valid && advance;
   assign req_ch.ready = advance;

   crg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_accept (in_accept),
      .in_data   (req_ch.data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_valid (front_valid),
      .out_ray   (front_ray),
      .out_sum   (front_sum)
   );

   crg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_ray    (front_ray),
      .in_sum    (front_sum),
      .out_valid (root_valid),
      .out_ray   (root_ray),
      .out_root  (root_len)
   );

   crg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (root_valid),
      .in_ray    (root_ray),
      .in_len    (root_len),
      .out_valid (div_valid),
      .out_ray   (div_ray),
      .out_quo   (div_quo)
   );

   // apply signs, force zero direction
   always_comb begin
      logic [2:0][WORD_BITS-1:0] dir;
      logic [WORD_BITS-1:0]      qe;
      for (int r = 0; r < 3; r++) begin
         qe = WORD_BITS'(div_quo[r]);
         if (div_ray.zero) begin
            dir[r] = '0;
         end else begin
            dir[r] = div_ray.neg[r] ? -qe : qe;
         end
      end
      out_data_in.origin_x = div_ray.origin[0];
      out_data_in.origin_y = div_ray.origin[1];
      out_data_in.origin_z = div_ray.origin[2];
      out_data_in.dir_x    = dir[0];
      out_data_in.dir_y    = dir[1];
      out_data_in.dir_z    = dir[2];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

   // a nonzero ray is normalized, so its length is at least 2^30
   a_len_norm: assert property (@(posedge clock) disable iff (reset)
      root_valid && !root_ray.zero |-> root_len[ROOT_BITS-1 -: 2] != 2'b00)
      else $error("ray length below normalized range");

   // a unit component never exceeds 1.0 in Q2.30
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid && !div_ray.zero |->
         div_quo[0] <= QUO_BITS'(1 << FRAC_DIR) && div_quo[1] <= QUO_BITS'(1 << FRAC_DIR) &&
         div_quo[2] <= QUO_BITS'(1 << FRAC_DIR))
      else $error("direction component out of range");

   // a free output register always lets the pipe take input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ch.ready)
      else $error("input blocked with empty output register");

   // a stalled pipe keeps its last item
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      div_valid && !advance |=> div_valid && $stable(div_quo) && $stable(div_ray))
      else $error("last stage changed during stall");

endmodule

FILE: test/camera_ray_generator_top_test.sv
`timescale 1ns / 1ps

module camera_ray_generator_top_test;
   import crg_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 175;
   localparam int SETTLE      = 90;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      crg_req_type item;
      bit          typed;
      crg_rsp_type ray;
   } row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0] csr_wdata;

   crg_req_if req_ch ();
   crg_rsp_if rsp_ch ();

   camera_ray_generator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic signed [WORD_BITS-1:0] camera_matrix [ENTRY_COUNT];
   logic [CFG_BITS-1:0] half_w, half_h, pix_size;

   crg_rsp_type pending_rays [$];
   row_type     directed_rows [$];
   int          errors;
   int          cycles;
   bit          quiet;
   bit          hold_request;
   bit          cur_typed;
   crg_rsp_type cur_ray;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // q16.16 world coordinate of a pixel centre, saturated
   function automatic logic signed [31:0] world_coord(logic [CFG_BITS-1:0] half,
                                                      logic [COORD_BITS-1:0] c);
      longint off, w2, w;
      off = longint'({c, 1'b1}) * longint'(pix_size);
      w2  = (longint'(half) <<< 1) - off;
      w   = (w2 + 1) >>> 1;
      if (w > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (w < -longint'(64'sh80000000)) return 32'sh80000000;
      return w[31:0];
   endfunction

   function automatic longint round_q16(longint p);
      return (p + 32768) >>> 16;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // ray for one pixel through the current matrix
   function automatic crg_rsp_type pixel_ray(crg_req_type it);
      logic signed [31:0] wx, wy;
      longint d [3];
      logic [63:0] a [3];
      logic [63:0] mx, tot, len, q;
      longint v;
      logic [31:0] org [3];
      logic [31:0] dir [3];
      crg_rsp_type o;
      wx = world_coord(half_w, it.pixel_x);
      wy = world_coord(half_h, it.pixel_y);
      mx = 0;
      for (int r = 0; r < 3; r++) begin
         d[r] = round_q16(longint'(camera_matrix[r*4]) * longint'(wx))
              + round_q16(longint'(camera_matrix[r*4+1]) * longint'(wy))
              - longint'(camera_matrix[r*4+2]);
         a[r] = (d[r] < 0) ? 64'(-d[r]) : 64'(d[r]);
         if (a[r] > mx) mx = a[r];
         org[r] = camera_matrix[r*4+3];
         dir[r] = 0;
      end
      if (mx != 0) begin
         while (mx < 64'h4000_0000) begin
            mx <<= 1;
            for (int r = 0; r < 3; r++) a[r] <<= 1;
         end
         while (mx >= 64'h8000_0000) begin
            mx >>= 1;
            for (int r = 0; r < 3; r++) a[r] >>= 1;
         end
         tot = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
         len = root_floor(tot);
         for (int r = 0; r < 3; r++) begin
            q = ((a[r] << 30) + (len >> 1)) / len;
            v = (d[r] < 0) ? -longint'(q) : longint'(q);
            dir[r] = v[31:0];
         end
      end
      o.origin_x = org[0];
      o.origin_y = org[1];
      o.origin_z = org[2];
      o.dir_x = dir[0];
      o.dir_y = dir[1];
      o.dir_z = dir[2];
      return o;
   endfunction

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // request transfers update the matrix or queue a ray
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (req_ch.data.cmd == CMD_LOAD) begin
            if (req_ch.data.entry_index < ENTRY_COUNT)
               camera_matrix[req_ch.data.entry_index] = req_ch.data.entry_value;
         end else if (cur_typed) begin
            pending_rays.push_back(cur_ray);
         end else begin
            pending_rays.push_back(pixel_ray(req_ch.data));
         end
      end
   end

   // result transfers against the oldest expected ray
   always @(posedge clock) begin
      crg_rsp_type w, g;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         g = rsp_ch.data;
         if (pending_rays.size() == 0) begin
            report("unexpected result", g.dir_x, 0);
         end else begin
            w = pending_rays.pop_front();
            if (g.origin_x !== w.origin_x) report("origin_x", g.origin_x, w.origin_x);
            if (g.origin_y !== w.origin_y) report("origin_y", g.origin_y, w.origin_y);
            if (g.origin_z !== w.origin_z) report("origin_z", g.origin_z, w.origin_z);
            if (g.dir_x !== w.dir_x) report("dir_x", g.dir_x, w.dir_x);
            if (g.dir_y !== w.dir_y) report("dir_y", g.dir_y, w.dir_y);
            if (g.dir_z !== w.dir_z) report("dir_z", g.dir_z, w.dir_z);
         end
      end
   end

   // result side ready, with stalls and one long hold-off
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clock);
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else begin
            n = gap_len();
            if (n == 0) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(negedge clock);
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   task automatic send(crg_req_type it, bit typed, crg_rsp_type ray);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      cur_typed = typed;
      cur_ray = ray;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering, wait for every ray, then let the pipe settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_rays.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // writes one configuration register, then drops csr_we again before returning
   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_HALF_WIDTH: half_w = v;
         CSR_HALF_HEIGHT: half_h = v;
         CSR_PIXEL_SIZE: pix_size = v;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic crg_req_type load_item(int idx, logic [31:0] v);
      crg_req_type it;
      it = '0;
      it.cmd = CMD_LOAD;
      it.entry_index = INDEX_BITS'(idx);
      it.entry_value = v;
      return it;
   endfunction

   function automatic crg_req_type pixel_item(int x, int y);
      crg_req_type it;
      it = '0;
      it.cmd = CMD_PIXEL;
      it.pixel_x = COORD_BITS'(x);
      it.pixel_y = COORD_BITS'(y);
      return it;
   endfunction

   function automatic void add_row(crg_req_type it, bit typed = 0,
                                   crg_rsp_type ray = '0);
      row_type r;
      r.item = it;
      r.typed = typed;
      r.ray = ray;
      directed_rows.push_back(r);
   endfunction

   // mostly pixels with random content, some loads of plausible coefficients
   function automatic crg_req_type random_item();
      crg_req_type it;
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      it = raw[$bits(crg_req_type)-1:0];
      if ($urandom_range(0, 4) == 0) begin
         it.cmd = CMD_LOAD;
         if ($urandom_range(0, 9) < 7)
            it.entry_value = $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
      end else begin
         it.cmd = CMD_PIXEL;
      end
      return it;
   endfunction

   initial begin
      crg_rsp_type flat;
      logic [CFG_BITS-1:0] hw, hh, ps;
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      cur_typed = 1'b0;
      cur_ray = '0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      for (int i = 0; i < ENTRY_COUNT; i++) camera_matrix[i] = 0;
      camera_matrix[0] = Q16_ONE;
      camera_matrix[5] = Q16_ONE;
      camera_matrix[10] = Q16_ONE;
      half_w = HALF_RESET;
      half_h = HALF_RESET;
      pix_size = PIXEL_SIZE_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset state, flat matrix, ignored loads, coefficient extremes
      add_row(pixel_item(0, 0));
      add_row(pixel_item(4095, 4095));
      foreach (camera_matrix[i]) add_row(load_item(i, 0));
      add_row(load_item(3, 32'h7fffffff));
      add_row(load_item(7, 32'h80000000));
      add_row(load_item(11, 32'h12345678));
      flat = '0;
      flat.origin_x = 32'h7fffffff;
      flat.origin_y = 32'h80000000;
      flat.origin_z = 32'h12345678;
      add_row(pixel_item(100, 200), 1, flat);
      add_row(load_item(12, 32'h00010000));
      add_row(load_item(15, 32'hffffffff));
      add_row(pixel_item(4095, 0), 1, flat);
      add_row(load_item(0, 32'h80000000));
      add_row(load_item(5, 32'h7fffffff));
      add_row(load_item(10, 32'h00010000));
      add_row(pixel_item(0, 4095));
      foreach (directed_rows[i])
         send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].ray);
      cur_typed = 1'b0;
      drain();

      // random phases, each under its own view setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin hw = HALF_RESET; hh = HALF_RESET; ps = PIXEL_SIZE_RESET; end
            1: begin hw = 0; hh = 0; ps = 0; end
            2: begin hw = '1; hh = '1; ps = 0; end
            3: begin hw = 0; hh = 0; ps = '1; end
            4: begin hw = '1; hh = '1; ps = '1; end
            default: begin
               hw = CFG_BITS'($urandom_range(0, 1 << 22));
               hh = CFG_BITS'($urandom_range(0, 1 << 22));
               ps = CFG_BITS'($urandom_range(0, 1 << 12));
            end
         endcase
         csr_write(CSR_HALF_WIDTH, hw);
         csr_write(CSR_HALF_HEIGHT, hh);
         csr_write(CSR_PIXEL_SIZE, ps);
         csr_write(CSR_UNUSED, CFG_BITS'($urandom));
         quiet = (p == 5);
         if (p == 1) hold_request = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) send(random_item(), 0, '0);
         drain();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
